// File: hdl/mmd_pkg.sv
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared types and constants of the k-sample MMD permutation engine.
// ----------------------------------------------------------------------------
package mmd_pkg;

	localparam int MAX_POOL   = 64;
	localparam int MAX_GROUPS = 4;
	localparam int POOL_W     = 6;
	localparam int KADDR_W    = 2 * POOL_W;
	localparam int SIZE_W     = 7;
	localparam int NSUM_W     = 9;
	localparam int SUM_W      = 48;
	localparam int STAT_W     = 64;
	localparam int NUM_W      = 52;
	localparam int DEN_W      = 2 * SIZE_W;
	localparam int DIV_CNT_W  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_3      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERM_COUNT  = 3'd5;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BIG = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] kernel_value;
		logic [31:0]        draw;
	} item_t;

	typedef struct packed {
		logic signed [63:0] statistic;
		logic               status;
		logic               last;
	} result_t;

endpackage

// File: hdl/mmd_kernel_ram.sv
// ----------------------------------------------------------------------------
// mmd_kernel_ram
// Pooled kernel matrix, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mmd_kernel_ram (
	input  logic                              clk,
	input  logic                              we,
	input  logic [mmd_pkg::KADDR_W-1:0]       waddr,
	input  logic signed [31:0]                wdata,
	input  logic [mmd_pkg::KADDR_W-1:0]       raddr,
	output logic signed [31:0]                rdata
);
	import mmd_pkg::*;

	logic signed [31:0] mem [MAX_POOL*MAX_POOL];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/mmd_order_ram.sv
// ----------------------------------------------------------------------------
// mmd_order_ram
// Shuffle order store, two registered read ports and one write port.
// Entries without a valid bit read as their own index.
// ----------------------------------------------------------------------------
module mmd_order_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       we,
	input  logic [mmd_pkg::POOL_W-1:0] waddr,
	input  logic [mmd_pkg::POOL_W-1:0] wdata,
	input  logic [mmd_pkg::POOL_W-1:0] raddr_a,
	input  logic [mmd_pkg::POOL_W-1:0] raddr_b,
	output logic [mmd_pkg::POOL_W-1:0] rdata_a,
	output logic [mmd_pkg::POOL_W-1:0] rdata_b
);
	import mmd_pkg::*;

	logic [POOL_W-1:0] mem [MAX_POOL];
	logic [MAX_POOL-1:0] vld_q;
	logic [POOL_W-1:0] ra_q, rb_q, da_q, db_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		da_q <= mem[raddr_a];
		db_q <= mem[raddr_b];
		ra_q <= raddr_a;
		rb_q <= raddr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata_a = vld_q[ra_q] ? da_q : ra_q;
	assign rdata_b = vld_q[rb_q] ? db_q : rb_q;

endmodule

// File: hdl/mmd_div.sv
// ----------------------------------------------------------------------------
// mmd_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module mmd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [mmd_pkg::NUM_W-1:0] num,
	input  logic [mmd_pkg::DEN_W-1:0]        den,
	output logic                             done,
	output logic signed [mmd_pkg::NUM_W-1:0] quo
);
	import mmd_pkg::*;

	logic                 busy_q, done_q, neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     mag_q;
	logic [DEN_W-1:0]     rem_q, den_q;
	logic [DEN_W:0]       rem_sh, rem_sub;
	logic                 qbit;

	always_comb begin
		rem_sh  = {rem_q, mag_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		qbit    = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_q <= den;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			mag_q <= {mag_q[NUM_W-2:0], qbit};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(mag_q) : $signed(mag_q);

endmodule

// File: hdl/permutation_k_sample_mmd.sv
// ----------------------------------------------------------------------------
// permutation_k_sample_mmd
// Fisher-Yates shuffle of a pooled kernel matrix driven by input draws,
// followed by the summed pairwise unbiased MMD squared of the groups.
//
//   port group  direction  moves
//   item        in         kernel entry write or one random draw
//   result      out        statistic, status and last flag
//   cfg         in         register writes, no handshake
//
// A kernel write is taken in ST_IDLE; a swap draw runs ST_MUL, ST_SRD,
// ST_SWI and ST_SWJ. The final draw of a permutation then scans every
// pair of each term through the order store and kernel memory, one pair
// a cycle, then drains the pipeline and runs the shared divider per term.
// Reset puts the order store back to identity through its valid bits.
// A result held by result_stall keeps the next in ST_EMIT; input stalls.
// ----------------------------------------------------------------------------
module permutation_k_sample_mmd (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  mmd_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output mmd_pkg::result_t                    result,
	input  logic                                cfg_write,
	input  logic [mmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mmd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mmd_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MUL    = 4'd1;
	localparam logic [3:0] ST_SRD    = 4'd2;
	localparam logic [3:0] ST_SWI    = 4'd3;
	localparam logic [3:0] ST_SWJ    = 4'd4;
	localparam logic [3:0] ST_TSTART = 4'd5;
	localparam logic [3:0] ST_SCAN   = 4'd6;
	localparam logic [3:0] ST_DRAIN  = 4'd7;
	localparam logic [3:0] ST_DSTART = 4'd8;
	localparam logic [3:0] ST_DWAIT  = 4'd9;
	localparam logic [3:0] ST_FINISH = 4'd10;
	localparam logic [3:0] ST_EMIT   = 4'd11;

	logic [2:0]          gcount_q;
	logic [SIZE_W-1:0]   size_q [MAX_GROUPS];
	logic [15:0]         perm_cnt_q, perm_done_q;
	logic [POOL_W-1:0]   swap_q;
	logic                fresh_q;
	logic [3:0]          state_q;
	logic [31:0]         draw_q;
	logic [POOL_W-1:0]   si_q, sj_q, di_q;
	logic [1:0]          ga_q, gb_q;
	logic [POOL_W-1:0]   ii_q, jj_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [STAT_W-1:0] stat_q;
	logic                err_q, last_q;
	logic                v_s1, v_s2;
	logic                result_valid_q;
	result_t             result_q;

	logic [2:0]          cnt;
	logic [NSUM_W-1:0]   n;
	logic [NSUM_W-1:0]   off [MAX_GROUPS];
	logic [POOL_W-1:0]   i_eff;
	logic                item_xfer, out_free, cfg_hit, clear;
	logic [SIZE_W-1:0]   na, nb;
	logic                same_grp, skip;
	logic [1:0]          nga, ngb;
	logic                ndone;
	logic [SIZE_W-1:0]   sip1;
	logic [38:0]         prod;
	logic [SIZE_W-1:0]   j7;
	logic                we_o;
	logic [POOL_W-1:0]   wa_o, wd_o, ra_o, rb_o, da_o, db_o;
	logic signed [31:0]  kdata;
	logic                div_start, div_done;
	logic signed [NUM_W-1:0] div_num, div_quo, acc_x;
	logic [DEN_W-1:0]    div_den;
	logic                last_j, last_i;
	logic [15:0]         perm_next;

	// group bookkeeping from the configuration registers
	always_comb begin
		if (gcount_q == 3'd0) begin
			cnt = 3'd1;
		end else if (gcount_q > 3'(MAX_GROUPS)) begin
			cnt = 3'(MAX_GROUPS);
		end else begin
			cnt = gcount_q;
		end
		n = '0;
		for (int g = 0; g < MAX_GROUPS; g++) begin
			off[g] = n;
			if (3'(g) < cnt) begin
				n = n + NSUM_W'(size_q[g]);
			end
		end
	end

	always_comb begin
		if (fresh_q || swap_q == '0 || NSUM_W'(swap_q) >= n) begin
			i_eff = POOL_W'(n - 1'b1);
		end else begin
			i_eff = swap_q;
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign cfg_hit    = cfg_write && (cfg_index == CFG_GROUP_COUNT ||
		cfg_index == CFG_SIZE_0 || cfg_index == CFG_SIZE_1 ||
		cfg_index == CFG_SIZE_2 || cfg_index == CFG_SIZE_3 ||
		cfg_index == CFG_PERM_COUNT);
	assign clear      = cfg_hit || (state_q == ST_FINISH);

	// term walk: within-group terms first, then each pair of groups
	always_comb begin
		na       = size_q[ga_q];
		nb       = size_q[gb_q];
		same_grp = (ga_q == gb_q);
		skip     = same_grp ? (na < SIZE_W'(2)) : (na == '0 || nb == '0);
		nga      = ga_q;
		ngb      = gb_q;
		ndone    = 1'b0;
		if (same_grp) begin
			if ({1'b0, ga_q} + 3'd1 < cnt) begin
				nga = ga_q + 2'd1;
				ngb = ga_q + 2'd1;
			end else if (cnt >= 3'd2) begin
				nga = 2'd0;
				ngb = 2'd1;
			end else begin
				ndone = 1'b1;
			end
		end else begin
			if ({1'b0, gb_q} + 3'd1 < cnt) begin
				ngb = gb_q + 2'd1;
			end else if ({1'b0, ga_q} + 3'd2 < cnt) begin
				nga = ga_q + 2'd1;
				ngb = ga_q + 2'd2;
			end else begin
				ndone = 1'b1;
			end
		end
	end

	assign last_j = (jj_q == POOL_W'(nb - 1'b1));
	assign last_i = (ii_q == POOL_W'(na - 1'b1));

	// swap target j from the draw
	assign sip1 = {1'b0, si_q} + SIZE_W'(1);
	assign prod = 39'(draw_q) * 39'(sip1);
	assign j7   = prod[38:32];

	// order store ports
	always_comb begin
		we_o = 1'b0;
		wa_o = si_q;
		wd_o = db_o;
		if (state_q == ST_SWI) begin
			we_o = 1'b1;
		end else if (state_q == ST_SWJ) begin
			we_o = 1'b1;
			wa_o = sj_q;
			wd_o = di_q;
		end
		if (state_q == ST_SRD) begin
			ra_o = si_q;
			rb_o = sj_q;
		end else begin
			ra_o = POOL_W'(off[ga_q] + NSUM_W'(ii_q));
			rb_o = POOL_W'(off[gb_q] + NSUM_W'(jj_q));
		end
	end

	mmd_order_ram u_order (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.we      (we_o),
		.waddr   (wa_o),
		.wdata   (wd_o),
		.raddr_a (ra_o),
		.raddr_b (rb_o),
		.rdata_a (da_o),
		.rdata_b (db_o)
	);

	mmd_kernel_ram u_kernel (
		.clk   (clk),
		.we    (item_xfer && item.opcode == OP_WRITE),
		.waddr ({item.row, item.col}),
		.wdata (item.kernel_value),
		.raddr ({da_o, db_o}),
		.rdata (kdata)
	);

	// per-term numerator and divisor
	always_comb begin
		acc_x = NUM_W'(acc_q);
		if (same_grp) begin
			case (cnt - 3'd1)
				3'd0:    div_num = '0;
				3'd1:    div_num = acc_x;
				3'd2:    div_num = acc_x <<< 1;
				3'd3:    div_num = acc_x + (acc_x <<< 1);
				default: div_num = '0;
			endcase
			div_den = DEN_W'(na) * DEN_W'(na - 1'b1);
		end else begin
			div_num = acc_x <<< 1;
			div_den = DEN_W'(na) * DEN_W'(nb);
		end
	end

	assign div_start = (state_q == ST_DSTART);

	mmd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign perm_next = perm_done_q + 16'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcount_q   <= 3'd2;
			for (int g = 0; g < MAX_GROUPS; g++) begin
				size_q[g] <= SIZE_W'(2);
			end
			perm_cnt_q <= 16'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_GROUP_COUNT: gcount_q   <= cfg_data[2:0];
				CFG_SIZE_0:      size_q[0]  <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_1:      size_q[1]  <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_2:      size_q[2]  <= cfg_data[SIZE_W-1:0];
				CFG_SIZE_3:      size_q[3]  <= cfg_data[SIZE_W-1:0];
				CFG_PERM_COUNT:  perm_cnt_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			swap_q      <= '0;
			fresh_q     <= 1'b1;
			perm_done_q <= '0;
			ga_q        <= '0;
			gb_q        <= '0;
			ii_q        <= '0;
			jj_q        <= '0;
			err_q       <= 1'b0;
			last_q      <= 1'b0;
			stat_q      <= '0;
		end else begin
			if (clear) begin
				fresh_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_xfer && item.opcode == OP_DRAW) begin
						if (n > NSUM_W'(MAX_POOL)) begin
							err_q   <= 1'b1;
							last_q  <= 1'b0;
							stat_q  <= '0;
							state_q <= ST_EMIT;
						end else if (n < NSUM_W'(2)) begin
							err_q   <= 1'b0;
							stat_q  <= '0;
							ga_q    <= '0;
							gb_q    <= '0;
							state_q <= ST_TSTART;
						end else begin
							si_q    <= i_eff;
							draw_q  <= item.draw;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					sj_q    <= (j7 > {1'b0, si_q}) ? si_q : j7[POOL_W-1:0];
					state_q <= ST_SRD;
				end
				ST_SRD: begin
					state_q <= ST_SWI;
				end
				ST_SWI: begin
					di_q    <= da_o;
					state_q <= ST_SWJ;
				end
				ST_SWJ: begin
					if (si_q > POOL_W'(1)) begin
						swap_q  <= si_q - 1'b1;
						fresh_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						err_q   <= 1'b0;
						stat_q  <= '0;
						ga_q    <= '0;
						gb_q    <= '0;
						state_q <= ST_TSTART;
					end
				end
				ST_TSTART: begin
					ii_q <= '0;
					jj_q <= '0;
					if (!skip) begin
						state_q <= ST_SCAN;
					end else if (ndone) begin
						state_q <= ST_FINISH;
					end else begin
						ga_q <= nga;
						gb_q <= ngb;
					end
				end
				ST_SCAN: begin
					if (last_j) begin
						jj_q <= '0;
						ii_q <= ii_q + 1'b1;
						if (last_i) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						jj_q <= jj_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (same_grp) begin
							stat_q <= stat_q + STAT_W'(div_quo);
						end else begin
							stat_q <= stat_q - STAT_W'(div_quo);
						end
						if (ndone) begin
							state_q <= ST_FINISH;
						end else begin
							ga_q    <= nga;
							gb_q    <= ngb;
							state_q <= ST_TSTART;
						end
					end
				end
				ST_FINISH: begin
					if (perm_next == perm_cnt_q) begin
						last_q      <= 1'b1;
						perm_done_q <= '0;
					end else begin
						last_q      <= 1'b0;
						perm_done_q <= perm_next;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pair pipeline: order read, kernel read, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN) && !(same_grp && ii_q == jj_q);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TSTART) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + SUM_W'(kdata);
		end
	end

	// output register, freed by a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			result_q.statistic <= stat_q;
			result_q.status    <= err_q ? STATUS_BIG : STATUS_OK;
			result_q.last      <= last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
